// ===== design/tpq_pkg.sv =====
`timescale 1ns / 1ps

package tpq_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SERVE  = 2'd2;

   // Response status codes carried in rsp_tuser.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [31:0] WAIT_LIMIT_RESET = 32'd900;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_PUT,
      S_SCAN,
      S_SRV_SHIFT,
      S_DONE
   } state_type;

   // One stored queue entry, as it sits in the entry memory.
   typedef struct packed {
      logic        urgent;
      logic [15:0] tag;
      logic [31:0] ticket;
      logic [31:0] arrival;
   } entry_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] ticket;
      logic [15:0] tag;
      logic        urgent;
      logic [31:0] waited;
   } result_type;

   typedef struct packed {
      logic [31:0] waited;
      logic        aged;
   } age_type;

endpackage

// ===== design/two_level_priority_queue_with_aging.sv =====
`timescale 1ns / 1ps

// Two-class queue with aging. A beat on req_ carries a request kind in
// req_tuser: tick advances time by one, insert stores an entry (urgent
// entries go behind the urgent ones already present but ahead of every
// normal one, normal entries go to the tail) and gets the next ticket
// number starting at 1, serve removes the first entry in queue order whose
// wait has reached wait_limit, or the head when none has. Every request
// returns exactly one rsp_ beat with a status in rsp_tuser. The entries
// live in one memory with a registered read port, and one wait unit
// (subtract and compare) is reused for every entry that a serve looks at.
// A tick or a rejected request goes straight to the response stage. An
// insert moves each entry behind its slot one place back (up to
// QUEUE_DEPTH - 1 of them), then writes the new entry. A serve scans the
// entries in order up to and including the one chosen, then moves every
// later entry forward to close the gap. When no entry has aged, the whole
// queue is scanned, then the head is taken and every other entry moves.
// The block takes one request at a time; a response left waiting on
// rsp_ does not keep the next request from being accepted and worked on.
// wait_limit is written through csr_wr_en and csr_wr_data and resets to
// 900; it should be written only while no request is in progress.

module two_level_priority_queue_with_aging #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,    // opcode
   input  logic [23:0] req_tdata,    // urgent, patient_tag, zero padding

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,    // status
   output logic [87:0] rsp_tdata,    // ticket, served_tag, served_urgent, waited, padding

   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import tpq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = $bits(entry_type);

   // Sequencer and bookkeeping registers.
   state_type   state_ff, state_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] ticket_ff, ticket_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ucount_ff, ucount_in;

   // Working registers for one request.
   logic          new_urgent_ff, new_urgent_in;
   logic [15:0]   new_tag_ff, new_tag_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] chk_idx_ff, chk_idx_in;
   logic          chk_vld_ff, chk_vld_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   entry_type     head_ff, head_in;
   result_type    res_ff, res_in;

   // Response register.
   logic        rsp_vld_ff, rsp_vld_in;
   result_type  rsp_res_ff, rsp_res_in;

   // Memory port signals.
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;
   entry_type     rd_entry;
   entry_type     new_entry;

   // Shared wait unit.
   logic [31:0] age_arrival;
   age_type     age;

   logic          req_fire;
   logic          rsp_free;
   logic [CW-1:0] idx_up;
   logic [CW-1:0] idx_down;
   logic          scan_more;
   logic          scan_hit;
   logic          scan_miss;
   logic          shift_up_more;
   logic          shift_down_more;

   assign rd_entry  = entry_type'(ram_rd_data);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_free  = !rsp_vld_ff || rsp_tready;

   assign idx_up    = idx_ff + CW'(1);
   assign idx_down  = idx_ff - CW'(1);
   assign scan_more = (scan_idx_ff < count_ff);
   assign scan_hit  = chk_vld_ff && age.aged;
   assign scan_miss = !chk_vld_ff && !scan_more;
   assign shift_up_more   = (idx_ff > pos_ff);
   assign shift_down_more = (idx_up < count_ff);

   assign new_entry.urgent  = new_urgent_ff;
   assign new_entry.tag     = new_tag_ff;
   assign new_entry.ticket  = ticket_ff + 32'd1;
   assign new_entry.arrival = now_ff;

   // While a candidate is being checked its fresh read data is aged; once
   // the scan has run out, the unit looks at the captured head instead.
   assign age_arrival = chk_vld_ff ? rd_entry.arrival : head_ff.arrival;

   tpq_age_unit u_age (
      .now_ticks  (now_ff),
      .arrival    (age_arrival),
      .wait_limit (limit_ff),
      .age        (age)
   );

   tpq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               priority if (req_tuser == OP_INSERT && count_ff != CW'(QUEUE_DEPTH)) begin
                  state_in = S_INS_SHIFT;
               end else if (req_tuser == OP_SERVE && count_ff != '0) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INS_SHIFT: begin
            if (!shift_up_more) begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (scan_hit || scan_miss) begin
               state_in = S_SRV_SHIFT;
            end
         end
         S_SRV_SHIFT: begin
            if (!shift_down_more) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      now_in        = now_ff;
      ticket_in     = ticket_ff;
      count_in      = count_ff;
      ucount_in     = ucount_ff;
      new_urgent_in = new_urgent_ff;
      new_tag_in    = new_tag_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      scan_idx_in   = scan_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      head_in       = head_ff;
      res_in        = res_ff;

      // A move that was read last cycle lands this cycle.
      ram_wr_en   = pend_ff;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = '0;

      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      rsp_res_in = rsp_res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_in        = '0;
               new_urgent_in = req_tdata[0];
               new_tag_in    = req_tdata[16:1];
               idx_in        = count_ff;
               pos_in        = req_tdata[0] ? ucount_ff : count_ff;
               scan_idx_in   = '0;
               chk_vld_in    = 1'b0;
               unique case (req_tuser)
                  OP_TICK: begin
                     now_in = now_ff + 32'd1;
                  end
                  OP_INSERT: begin
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        res_in.status = ST_FULL;
                     end
                  end
                  OP_SERVE: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                     end
                  end
                  default: begin
                     // An unused kind leaves the state alone and answers zero.
                  end
               endcase
            end
         end
         S_INS_SHIFT: begin
            // Walk from the tail down to the insert slot, moving each
            // entry one place back.
            if (shift_up_more) begin
               ram_rd_addr  = idx_down[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
               idx_in       = idx_down;
            end
         end
         S_INS_PUT: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = pos_ff[AW-1:0];
            ram_wr_data   = EW'(new_entry);
            ticket_in     = new_entry.ticket;
            count_in      = count_ff + CW'(1);
            ucount_in     = ucount_ff + CW'(new_urgent_ff);
            res_in.status = ST_OK;
            res_in.ticket = new_entry.ticket;
         end
         S_SCAN: begin
            if (chk_vld_ff && chk_idx_ff == '0) begin
               head_in = rd_entry;
            end
            if (scan_hit) begin
               idx_in        = chk_idx_ff;
               chk_vld_in    = 1'b0;
               res_in.status = ST_OK;
               res_in.ticket = rd_entry.ticket;
               res_in.tag    = rd_entry.tag;
               res_in.urgent = rd_entry.urgent;
               res_in.waited = age.waited;
               ucount_in     = ucount_ff - CW'(rd_entry.urgent);
            end else if (scan_miss) begin
               // Nobody has waited long enough: serve the head.
               idx_in        = '0;
               res_in.status = ST_OK;
               res_in.ticket = head_ff.ticket;
               res_in.tag    = head_ff.tag;
               res_in.urgent = head_ff.urgent;
               res_in.waited = age.waited;
               ucount_in     = ucount_ff - CW'(head_ff.urgent);
            end else if (scan_more) begin
               ram_rd_addr = scan_idx_ff[AW-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff;
               scan_idx_in = scan_idx_ff + CW'(1);
            end else begin
               chk_vld_in = 1'b0;
            end
         end
         S_SRV_SHIFT: begin
            // Close the gap left by the served entry.
            if (shift_down_more) begin
               ram_rd_addr  = idx_up[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
               idx_in       = idx_up;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_res_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         limit_ff   <= WAIT_LIMIT_RESET;
         now_ff     <= '0;
         ticket_ff  <= '0;
         count_ff   <= '0;
         ucount_ff  <= '0;
         chk_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         limit_ff   <= limit_in;
         now_ff     <= now_in;
         ticket_ff  <= ticket_in;
         count_ff   <= count_in;
         ucount_ff  <= ucount_in;
         chk_vld_ff <= chk_vld_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      new_urgent_ff <= new_urgent_in;
      new_tag_ff    <= new_tag_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      pend_addr_ff  <= pend_addr_in;
      head_ff       <= head_in;
      res_ff        <= res_in;
      rsp_res_ff    <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {7'd0, rsp_res_ff.waited, rsp_res_ff.urgent,
                        rsp_res_ff.tag, rsp_res_ff.ticket};

endmodule

// ===== design/tpq_ram.sv =====
`timescale 1ns / 1ps

module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tpq_age_unit.sv =====
`timescale 1ns / 1ps

module tpq_age_unit (
   input  logic [31:0]          now_ticks,
   input  logic [31:0]          arrival,
   input  logic [31:0]          wait_limit,
   output tpq_pkg::age_type     age
);
   import tpq_pkg::*;

   logic [31:0] waited;

   // The wait wraps modulo 2^32, exactly like the time counter.
   assign waited     = now_ticks - arrival;
   assign age.waited = waited;
   assign age.aged   = (waited >= wait_limit);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the two-class aging queue. It drives request
// beats with random idle gaps, predicts every response from its own copy of
// the queue, and moves the wait limit through several values between
// phases while the block is idle.
module testbench;
   import tpq_pkg::*;

   localparam int          QUEUE_DEPTH = 16;
   localparam int          PHASE_ITEMS = 210;
   localparam int unsigned STALL_LIMIT = 4000;

   // The package names every request kind except the one the block ignores.
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser   = OP_TICK;
   logic [23:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [87:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int unsigned responses_seen = 0;

   // The tracker mirrors the queue contents, the tick clock and the ticket
   // counter. Each accepted request beat produces exactly one expected
   // response, which is queued until the matching rsp_ beat arrives.
   class tpq_tracker;
      entry_type   line[$];
      result_type  outcomes[$];
      logic [31:0] age_limit;
      logic [31:0] now;
      logic [31:0] last_ticket;
      int unsigned failures;

      function new();
         age_limit   = WAIT_LIMIT_RESET;
         now         = '0;
         last_ticket = '0;
         failures    = 0;
      endfunction

      function void accept_request(logic [1:0] op, logic urgent, logic [15:0] tag);
         result_type  r;
         entry_type   e;
         int          pos;
         int          i;
         logic [31:0] waited;
         r = '0;
         case (op)
            OP_TICK: begin
               now = now + 32'd1;
            end
            OP_INSERT: begin
               if (line.size() >= QUEUE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  // Urgent entries queue up behind the urgent block only.
                  pos = line.size();
                  if (urgent) begin
                     pos = 0;
                     while (pos < line.size() && line[pos].urgent) pos++;
                  end
                  last_ticket = last_ticket + 32'd1;
                  e.urgent    = urgent;
                  e.tag       = tag;
                  e.ticket    = last_ticket;
                  e.arrival   = now;
                  line.insert(pos, e);
                  r.status    = ST_OK;
                  r.ticket    = last_ticket;
               end
            end
            OP_SERVE: begin
               if (line.size() == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  // The first aged entry in queue order wins, else the head.
                  pos = -1;
                  for (i = 0; i < line.size(); i++) begin
                     waited = now - line[i].arrival;
                     if (pos < 0 && waited >= age_limit) pos = i;
                  end
                  if (pos < 0) pos = 0;
                  r.status = ST_OK;
                  r.ticket = line[pos].ticket;
                  r.tag    = line[pos].tag;
                  r.urgent = line[pos].urgent;
                  r.waited = now - line[pos].arrival;
                  line.delete(pos);
               end
            end
            default: begin
            end
         endcase
         outcomes.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [1:0] status, logic [87:0] data);
         result_type want;
         if (outcomes.size() == 0) begin
            $display("%0t: response with nothing pending, expected none, got status %0h data %0h",
                     $time, status, data);
            failures++;
            return;
         end
         want = outcomes.pop_front();
         compare_field("status",        32'(want.status), 32'(status));
         compare_field("ticket",        want.ticket,      data[31:0]);
         compare_field("served_tag",    32'(want.tag),    32'(data[47:32]));
         compare_field("served_urgent", 32'(want.urgent), 32'(data[48]));
         compare_field("waited",        want.waited,      data[80:49]);
      endfunction
   endclass

   tpq_tracker tracker = new();

   two_level_priority_queue_with_aging #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Idle lengths are mostly zero or a few cycles, with a rare long one so
   // that gaps land on every state of a long serve scan.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request beat and holds it until the block takes it. The
   // valid stays high into the next request when no gap follows, so it is
   // never lowered and raised within one time step.
   task automatic send_request(input logic [1:0] op, input logic urgent,
                               input logic [15:0] tag, input int unsigned gap);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, tag, urgent};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.accept_request(op, urgent, tag);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The limit is only changed once every response is back, plus a few
   // cycles for the control to return to idle.
   task automatic write_wait_limit(input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (tracker.outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.age_limit = value;
   endtask

   // A random phase. The insert and serve shares decide whether the queue
   // tends to fill up or drain; ticks make up the rest so entries age, and
   // a small share of beats carry the unused request kind.
   task automatic run_random(input int unsigned count, input int unsigned insert_pct,
                             input int unsigned serve_pct);
      int unsigned n;
      int unsigned r;
      logic [1:0]  op;
      bit          steady;
      steady = 1'b0;
      for (n = 0; n < count; n++) begin
         if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 3)                            op = OP_UNUSED;
         else if (r < 3 + insert_pct)          op = OP_INSERT;
         else if (r < 3 + insert_pct + serve_pct) op = OP_SERVE;
         else                                  op = OP_TICK;
         send_request(op, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                      steady ? 0 : idle_length());
      end
   endtask

   // Main stimulus: directed beats first, then random phases under a
   // series of wait limits including both extremes.
   initial begin : stimulus
      int          p;
      int          k;
      logic [31:0] limit;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset limit: a serve on the empty queue,
      // the ignored request kind, a tick, then a fill to full with both
      // classes and extreme tags, inserts on the full queue, and serves
      // that pull the urgent entries out first.
      send_request(OP_SERVE,  1'b0, 16'h0000, 0);
      send_request(OP_UNUSED, 1'b1, 16'hFFFF, 0);
      send_request(OP_TICK,   1'b0, 16'h0000, 0);
      send_request(OP_INSERT, 1'b0, 16'h0000, 0);
      send_request(OP_INSERT, 1'b1, 16'hFFFF, 0);
      for (k = 2; k < QUEUE_DEPTH; k++) begin
         send_request(OP_INSERT, 1'(k % 3 == 0), 16'(16'h1 << k), 0);
      end
      send_request(OP_INSERT, 1'b1, 16'hA5A5, 0);
      send_request(OP_INSERT, 1'b0, 16'h5A5A, 0);
      send_request(OP_TICK,   1'b0, 16'h0000, 0);
      send_request(OP_SERVE,  1'b0, 16'h0000, 0);
      send_request(OP_SERVE,  1'b0, 16'h0000, 0);
      send_request(OP_SERVE,  1'b0, 16'h0000, 0);

      run_random(PHASE_ITEMS, 45, 35);

      for (p = 0; p < 8; p++) begin
         case (p)
            0:       limit = 32'd0;
            1:       limit = 32'hFFFF_FFFF;
            7:       limit = 32'h8000_0000;
            default: limit = $urandom_range(1, 40);
         endcase
         write_wait_limit(limit);
         if (p % 2 == 1) run_random(PHASE_ITEMS, 55, 25);
         else            run_random(PHASE_ITEMS, 30, 45);
      end

      // Drain: every expected response must come back, then allow the
      // longest operation time for anything stray to show up.
      req_tvalid <= 1'b0;
      while (tracker.outcomes.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Response side. Outputs are sampled at the edge, before the block's
   // registers update. Ready drops for random stretches with calm periods
   // in between, and once the sink holds off for a long stretch while the
   // sender keeps offering, so the block fills its response register and
   // stalls its input.
   initial begin : response_sink
      int unsigned hold;
      int unsigned cycle_count;
      bit          calm;
      bit          pressure_done;
      hold          = 0;
      cycle_count   = 0;
      calm          = 1'b0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_response(rsp_tuser, rsp_tdata);
            responses_seen++;
         end
         cycle_count++;
         if (cycle_count % 300 == 0) calm = ($urandom_range(0, 2) == 0);
         if (hold > 0) begin
            hold--;
         end else if (!pressure_done && responses_seen >= 400) begin
            hold          = 500;
            pressure_done = 1'b1;
         end else if (!calm) begin
            hold = idle_length();
         end
         rsp_tready <= (hold == 0);
      end
   end

   // Watchdog: a quiet run that reaches STALL_LIMIT, with no beat on either side,
   // means the block hung or dropped a response.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
